// ===== rtl/stepper_step_pulse_generator_macros.svh =====
// Assertion helpers for the checker of the step pulse generator.
// Each one samples on clk and is held off while rst_n is low.
`ifndef STEPPER_STEP_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_STEP_PULSE_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sspg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SSPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sspg assertion failed");

`endif

// ===== rtl/sspg_pkg.sv =====
package sspg_pkg;

  // Default prescaled tick frequency
  localparam int TICK_HZ_DEF = 5000000;

  // Field widths
  localparam int OP_W     = 3;
  localparam int STEPS_W  = 32;
  localparam int RATE_W   = 15;
  localparam int REM_W    = 31;
  localparam int PERIOD_W = 17;
  localparam int OVF_W    = 16;
  localparam int SKIP_W   = 11;

  // Rate conversion constants
  localparam int RATE_MAX        = 20000;
  localparam int RATE_DIRECT_MIN = 78;
  localparam int RATE_PLUS_MAX   = 10;
  localparam int SKIP_RATE_ZERO  = 2000;
  localparam int SKIP_DIVIDEND   = 1000 - 1;
  localparam int RATE_DEFAULT    = 100;
  localparam int PERIOD_MAX      = 131071;

  // Stream packing
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int IN_DIR_BIT   = 0;
  localparam int IN_STEPS_LSB = 1;

  localparam int OUT_PULSE_BIT   = 0;
  localparam int OUT_DIR_BIT     = 1;
  localparam int OUT_ENABLE_BIT  = 2;
  localparam int OUT_STEPPING_BIT = 3;
  localparam int OUT_REM_LSB     = 4;
  localparam int OUT_STATUS_BIT  = OUT_REM_LSB + REM_W;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_STEP_RATE    = 1'b0,
    REG_ENABLE_LEVEL = 1'b1
  } reg_idx_t;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_INIT       = 3'd1,
    OP_LOAD       = 3'd2,
    OP_LOAD_START = 3'd3,
    OP_START      = 3'd4,
    OP_STOP       = 3'd5,
    OP_END        = 3'd6
  } op_t;

endpackage

// ===== rtl/stepper_step_pulse_generator.sv =====
// Step/direction/enable generator for a stepper driver. Each input transaction carries one
// operation (tick, init, load, load-and-start, start, stop, end) and yields exactly one result
// transaction, registered, in the next cycle; with out_tready held high and no register write
// pending or in progress, a new transaction is taken every cycle. A step_rate write of a nonzero
// rate up to 20000, taken while the block is not off, runs the shared restoring divider one
// quotient bit a cycle; during that time in_tready and cfg_ready stay low. Zero rate and the
// enable level are applied at once.
module stepper_step_pulse_generator #(
  parameter int TICK_HZ = sspg_pkg::TICK_HZ_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tuser: operation[2:0]
  input  logic [sspg_pkg::OP_W-1:0]      in_tuser,
  // tdata: direction[0], steps[32:1], zero[39:33]
  input  logic [sspg_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: step_pulse[0], direction_level[1], enable_pin[2], is_stepping[3],
  //        remaining_steps[34:4], status[35], zero[39:36]
  output logic [sspg_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [sspg_pkg::RATE_W-1:0]     cfg_data
);
  import sspg_pkg::*;

  localparam int DIV_W = $clog2(TICK_HZ);
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int KHZ_RAW = (TICK_HZ - 1) / 1000;
  localparam int KHZ_LIMIT = (KHZ_RAW > PERIOD_MAX) ? PERIOD_MAX : KHZ_RAW;
  localparam int PER_DEF_RAW = (TICK_HZ - 1) / RATE_DEFAULT;
  localparam int PER_DEF = (PER_DEF_RAW > PERIOD_MAX) ? PERIOD_MAX : PER_DEF_RAW;

  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_INITED   = 2'd1,
    ST_STEPPING = 2'd2,
    ST_HALTED   = 2'd3
  } run_st_t;

  run_st_t               state_r, state_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic                  fwd_r, fwd_nxt;
  logic                  timer_r, timer_nxt;
  logic [PERIOD_W-1:0]   tick_r, tick_nxt;
  logic [OVF_W-1:0]      ovf_r, ovf_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [SKIP_W-1:0]     skip_r, skip_nxt;
  logic                  dir_pin_r, dir_pin_nxt;
  logic                  drv_r, drv_nxt;
  logic                  eal_r, eal_nxt;
  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Divider datapath
  logic                  direct_r, direct_nxt;
  logic                  plus_r, plus_nxt;
  logic [RATE_W-1:0]     divisor_r, divisor_nxt;
  logic [RATE_W-1:0]     drem_r, drem_nxt;
  logic [DIV_W-1:0]      quo_r, quo_nxt;

  logic                  in_fire;
  logic                  cfg_fire;
  logic [RATE_W:0]       shifted;
  logic                  qbit;
  logic [DIV_W-1:0]      quo_step;

  assign cfg_ready  = !busy_r;
  assign in_tready  = !busy_r && !cfg_valid && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // One restoring division step
  assign shifted  = {drem_r, quo_r[DIV_W-1]};
  assign qbit     = (shifted >= {1'b0, divisor_r});
  assign quo_step = {quo_r[DIV_W-2:0], qbit};

  always_comb begin
    op_t                op;
    logic               dir_in;
    logic [STEPS_W-1:0] steps_in;
    logic               ok;
    logic               pulse;
    logic               load_ok;
    logic [OVF_W-1:0]   ovf_inc;
    logic [RATE_W:0]    diff;

    op       = op_t'(in_tuser);
    dir_in   = in_tdata[IN_DIR_BIT];
    steps_in = in_tdata[IN_STEPS_LSB +: STEPS_W];
    ok       = 1'b1;
    pulse    = 1'b0;
    load_ok  = (state_r != ST_OFF) && !steps_in[STEPS_W-1] && (steps_in != '0);
    ovf_inc  = ovf_r + OVF_W'(1);
    diff     = shifted - {1'b0, divisor_r};

    state_nxt     = state_r;
    rem_nxt       = rem_r;
    fwd_nxt       = fwd_r;
    timer_nxt     = timer_r;
    tick_nxt      = tick_r;
    ovf_nxt       = ovf_r;
    period_nxt    = period_r;
    skip_nxt      = skip_r;
    dir_pin_nxt   = dir_pin_r;
    drv_nxt       = drv_r;
    eal_nxt       = eal_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    direct_nxt    = direct_r;
    plus_nxt      = plus_r;
    divisor_nxt   = divisor_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;

    if (cfg_fire) begin
      if (cfg_index == REG_STEP_RATE) begin
        if (state_r != ST_OFF && cfg_data <= RATE_W'(RATE_MAX)) begin
          tick_nxt  = '0;
          timer_nxt = (state_r != ST_HALTED);
          if (cfg_data == '0) begin
            skip_nxt   = SKIP_W'(SKIP_RATE_ZERO);
            period_nxt = PERIOD_W'(KHZ_LIMIT);
          end else begin
            busy_nxt    = 1'b1;
            cnt_nxt     = CNT_W'(DIV_W);
            direct_nxt  = (cfg_data >= RATE_W'(RATE_DIRECT_MIN));
            plus_nxt    = (cfg_data <= RATE_W'(RATE_PLUS_MAX));
            divisor_nxt = cfg_data;
            drem_nxt    = '0;
            quo_nxt     = (cfg_data >= RATE_W'(RATE_DIRECT_MIN)) ?
                          DIV_W'(TICK_HZ - 1) : DIV_W'(SKIP_DIVIDEND);
          end
        end
      end else begin
        eal_nxt = cfg_data[0];
      end
    end else if (busy_r) begin
      drem_nxt = qbit ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
      quo_nxt  = quo_step;
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        if (direct_r) begin
          skip_nxt   = '0;
          period_nxt = (quo_step[DIV_W-1:PERIOD_W] != '0) ?
                       PERIOD_W'(PERIOD_MAX) : quo_step[PERIOD_W-1:0];
        end else begin
          period_nxt = PERIOD_W'(KHZ_LIMIT);
          skip_nxt   = quo_step[SKIP_W-1:0] + SKIP_W'(plus_r);
        end
      end
    end

    if (in_fire) begin
      unique case (op)
        OP_TICK: begin
          if (timer_r) begin
            if (tick_r >= period_r) begin
              tick_nxt = '0;
              ovf_nxt  = ovf_inc;
              if (ovf_inc > OVF_W'(skip_r)) begin
                ovf_nxt = '0;
                if (state_r == ST_OFF) begin
                  timer_nxt = 1'b0;
                  drv_nxt   = 1'b0;
                end else if (state_r == ST_STEPPING) begin
                  if (rem_r != '0) begin
                    dir_pin_nxt = fwd_r;
                    pulse       = 1'b1;
                    rem_nxt     = rem_r - REM_W'(1);
                  end
                  if (rem_r <= REM_W'(1)) begin
                    drv_nxt   = 1'b0;
                    state_nxt = ST_HALTED;
                  end
                end
              end
            end else begin
              tick_nxt = tick_r + PERIOD_W'(1);
            end
          end
        end
        OP_INIT: begin
          if (state_r != ST_OFF) begin
            ok = 1'b0;
          end else begin
            rem_nxt     = '0;
            fwd_nxt     = 1'b1;
            dir_pin_nxt = 1'b0;
            drv_nxt     = 1'b0;
            period_nxt  = PERIOD_W'(PER_DEF);
            skip_nxt    = '0;
            tick_nxt    = '0;
            timer_nxt   = 1'b1;
            state_nxt   = ST_INITED;
          end
        end
        OP_LOAD: begin
          ok = load_ok;
          if (load_ok) begin
            fwd_nxt = dir_in;
            rem_nxt = steps_in[REM_W-1:0];
          end
        end
        OP_LOAD_START: begin
          ok = load_ok && (state_r != ST_STEPPING);
          if (load_ok) begin
            fwd_nxt = dir_in;
            rem_nxt = steps_in[REM_W-1:0];
            if (state_r != ST_STEPPING) begin
              drv_nxt   = 1'b1;
              timer_nxt = 1'b1;
              state_nxt = ST_STEPPING;
            end
          end
        end
        OP_START: begin
          if (state_r == ST_OFF || state_r == ST_STEPPING || rem_r == '0) begin
            ok = 1'b0;
          end else begin
            drv_nxt   = 1'b1;
            timer_nxt = 1'b1;
            state_nxt = ST_STEPPING;
          end
        end
        OP_STOP: begin
          if (state_r == ST_OFF || state_r == ST_HALTED) begin
            ok = 1'b0;
          end else begin
            drv_nxt   = 1'b0;
            state_nxt = ST_HALTED;
          end
        end
        OP_END: begin
          if (state_r == ST_OFF) begin
            ok = 1'b0;
          end else begin
            timer_nxt   = 1'b0;
            drv_nxt     = 1'b0;
            dir_pin_nxt = 1'b0;
            rem_nxt     = '0;
            fwd_nxt     = 1'b1;
            period_nxt  = PERIOD_W'(PER_DEF);
            skip_nxt    = '0;
            state_nxt   = ST_OFF;
          end
        end
        default: ok = 1'b0;
      endcase

      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_PULSE_BIT]      = pulse;
      out_data_nxt[OUT_DIR_BIT]        = dir_pin_nxt;
      out_data_nxt[OUT_ENABLE_BIT]     = drv_nxt ? eal_r : !eal_r;
      out_data_nxt[OUT_STEPPING_BIT]   = (state_nxt == ST_STEPPING);
      out_data_nxt[OUT_REM_LSB +: REM_W] = rem_nxt;
      out_data_nxt[OUT_STATUS_BIT]     = !ok;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OFF;
      rem_r       <= '0;
      fwd_r       <= 1'b1;
      timer_r     <= 1'b0;
      tick_r      <= '0;
      ovf_r       <= '0;
      period_r    <= PERIOD_W'(PER_DEF);
      skip_r      <= '0;
      dir_pin_r   <= 1'b0;
      drv_r       <= 1'b0;
      eal_r       <= 1'b1;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      fwd_r       <= fwd_nxt;
      timer_r     <= timer_nxt;
      tick_r      <= tick_nxt;
      ovf_r       <= ovf_nxt;
      period_r    <= period_nxt;
      skip_r      <= skip_nxt;
      dir_pin_r   <= dir_pin_nxt;
      drv_r       <= drv_nxt;
      eal_r       <= eal_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Divider datapath, no reset needed
  always_ff @(posedge clk) begin
    direct_r  <= direct_nxt;
    plus_r    <= plus_nxt;
    divisor_r <= divisor_nxt;
    drem_r    <= drem_nxt;
    quo_r     <= quo_nxt;
  end

endmodule

// ===== rtl/sspg_checker.sv =====
`include "stepper_step_pulse_generator_macros.svh"

module sspg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sspg_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sspg_pkg::*;

  // A stalled result holds
  `SSPG_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Every input transaction yields a result on the next cycle
  `SSPG_ASSERT_NXT(a_in_to_out, in_tvalid && in_tready, out_tvalid)

  // A register write and an input transaction never land together
  `SSPG_ASSERT_IMP(a_no_overlap, cfg_valid && cfg_ready, !(in_tvalid && in_tready))

  // A step that leaves the move stopped must have been its last one
  `SSPG_ASSERT_IMP(a_last_step,
    out_tvalid && out_tdata[OUT_PULSE_BIT] && !out_tdata[OUT_STEPPING_BIT],
    out_tdata[OUT_REM_LSB +: REM_W] == '0)

endmodule

bind stepper_step_pulse_generator sspg_checker u_sspg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/stepper_step_pulse_generator_tb.sv =====
`timescale 1ns / 100ps

module stepper_step_pulse_generator_tb;
  import sspg_pkg::*;

  localparam int TB_TICK_HZ = 1000000;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEM_TARGET = 400;
  localparam int unsigned CALM_FROM = 340;
  localparam int unsigned TICK_BURST_MAX = 48;
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  typedef enum logic [1:0] {
    RUN_OFF      = 2'd0,
    RUN_INITED   = 2'd1,
    RUN_STEPPING = 2'd2,
    RUN_HALTED   = 2'd3
  } run_t;

  typedef struct packed {
    logic             step_pulse;
    logic             direction_level;
    logic             enable_pin;
    logic             is_stepping;
    logic [REM_W-1:0] remaining_steps;
    logic             status;
  } pin_frame_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               dir;
    logic [STEPS_W-1:0] steps;
    logic               typed;
    pin_frame_t         want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [RATE_W-1:0]     cfg_data = '0;

  stepper_step_pulse_generator #(
    .TICK_HZ(TB_TICK_HZ)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the motor controller
  run_t                motor_state;
  logic [STEPS_W-1:0]  steps_left;
  logic                heading_fwd;
  logic                timer_on;
  logic [PERIOD_W-1:0] tick_cnt;
  logic [OVF_W-1:0]    wrap_cnt;
  logic [PERIOD_W-1:0] period_top;
  logic [SKIP_W-1:0]   wraps_skip;
  logic                dir_latch;
  logic                drv_latch;
  logic                en_level;

  pin_frame_t  frames_due[$];
  plan_row_t   plan[$];
  pin_frame_t  seen;
  pin_frame_t  due;

  bit          idle_mix = 1'b1;
  int unsigned faults = 0;
  int unsigned cmds_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned writes_done = 0;
  int unsigned pulses_seen = 0;
  int unsigned cycles = 0;
  int unsigned phase_no;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void retime(input int unsigned rate);
    int unsigned per;
    int unsigned khz;
    khz = (TB_TICK_HZ - 1) / 1000;
    if (rate == 0) begin
      wraps_skip = SKIP_W'(SKIP_RATE_ZERO);
      per = khz;
    end else if (rate >= RATE_DIRECT_MIN) begin
      wraps_skip = '0;
      per = (TB_TICK_HZ - 1) / rate;
    end else if (rate > RATE_PLUS_MAX) begin
      wraps_skip = SKIP_W'(SKIP_DIVIDEND / rate);
      per = khz;
    end else begin
      wraps_skip = SKIP_W'(SKIP_DIVIDEND / rate + 1);
      per = khz;
    end
    period_top = (per > PERIOD_MAX) ? PERIOD_W'(PERIOD_MAX) : PERIOD_W'(per);
  endfunction

  function automatic void reset_motor();
    motor_state = RUN_OFF;
    steps_left = '0;
    heading_fwd = 1'b1;
    timer_on = 1'b0;
    tick_cnt = '0;
    wrap_cnt = '0;
    dir_latch = 1'b0;
    drv_latch = 1'b0;
    en_level = 1'b1;
    retime(RATE_DEFAULT);
  endfunction

  function automatic void write_register(input logic idx, input logic [RATE_W-1:0] val);
    if (idx == REG_STEP_RATE) begin
      if (motor_state != RUN_OFF && val <= RATE_MAX) begin
        retime(val);
        tick_cnt = '0;
        timer_on = (motor_state != RUN_HALTED);
      end
    end else begin
      en_level = val[0];
    end
  endfunction

  function automatic logic tick_timer();
    if (!timer_on) return 1'b0;
    if (tick_cnt >= period_top) begin
      tick_cnt = '0;
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      return 1'b0;
    end
    wrap_cnt = wrap_cnt + 1'b1;
    if (wrap_cnt <= wraps_skip) return 1'b0;
    wrap_cnt = '0;
    if (motor_state == RUN_OFF) begin
      timer_on = 1'b0;
      drv_latch = 1'b0;
      return 1'b0;
    end
    if (motor_state != RUN_STEPPING) return 1'b0;
    if (steps_left != 0) begin
      dir_latch = heading_fwd;
      steps_left = steps_left - 1'b1;
      if (steps_left == 0) begin
        drv_latch = 1'b0;
        motor_state = RUN_HALTED;
      end
      return 1'b1;
    end
    drv_latch = 1'b0;
    motor_state = RUN_HALTED;
    return 1'b0;
  endfunction

  function automatic logic take_steps(input logic dir, input logic [STEPS_W-1:0] n);
    if (motor_state == RUN_OFF || n == 0 || n[STEPS_W-1]) return 1'b0;
    heading_fwd = dir;
    steps_left = n;
    return 1'b1;
  endfunction

  function automatic logic engage();
    if (motor_state == RUN_OFF || motor_state == RUN_STEPPING || steps_left == 0) return 1'b0;
    drv_latch = 1'b1;
    timer_on = 1'b1;
    motor_state = RUN_STEPPING;
    return 1'b1;
  endfunction

  function automatic pin_frame_t step_motor(input logic [OP_W-1:0] op, input logic dir,
                                            input logic [STEPS_W-1:0] n);
    pin_frame_t f;
    logic ok;
    logic pulse;
    ok = 1'b1;
    pulse = 1'b0;
    case (op)
      OP_TICK: pulse = tick_timer();
      OP_INIT: begin
        if (motor_state != RUN_OFF) begin
          ok = 1'b0;
        end else begin
          steps_left = '0;
          heading_fwd = 1'b1;
          dir_latch = 1'b0;
          drv_latch = 1'b0;
          retime(RATE_DEFAULT);
          tick_cnt = '0;
          timer_on = 1'b1;
          motor_state = RUN_INITED;
        end
      end
      OP_LOAD: ok = take_steps(dir, n);
      OP_LOAD_START: begin
        ok = take_steps(dir, n);
        if (ok) ok = engage();
      end
      OP_START: ok = engage();
      OP_STOP: begin
        if (motor_state == RUN_OFF || motor_state == RUN_HALTED) begin
          ok = 1'b0;
        end else begin
          drv_latch = 1'b0;
          motor_state = RUN_HALTED;
        end
      end
      OP_END: begin
        if (motor_state == RUN_OFF) begin
          ok = 1'b0;
        end else begin
          timer_on = 1'b0;
          drv_latch = 1'b0;
          dir_latch = 1'b0;
          steps_left = '0;
          heading_fwd = 1'b1;
          retime(RATE_DEFAULT);
          motor_state = RUN_OFF;
        end
      end
      default: ok = 1'b0;
    endcase
    f.step_pulse = pulse;
    f.direction_level = dir_latch;
    f.enable_pin = drv_latch ? en_level : ~en_level;
    f.is_stepping = (motor_state == RUN_STEPPING);
    f.remaining_steps = steps_left[REM_W-1:0];
    f.status = ~ok;
    return f;
  endfunction

  function automatic int unsigned items_left();
    if (cmds_sent + ticks_sent >= ITEM_TARGET) return 0;
    return ITEM_TARGET - cmds_sent - ticks_sent;
  endfunction

  task automatic script(input logic [OP_W-1:0] op, input logic dir, input logic [STEPS_W-1:0] n,
                        input logic typed, input logic en, input logic stp,
                        input logic [REM_W-1:0] rem, input logic st);
    plan_row_t r;
    r.op = op;
    r.dir = dir;
    r.steps = n;
    r.typed = typed;
    r.want.step_pulse = 1'b0;
    r.want.direction_level = 1'b0;
    r.want.enable_pin = en;
    r.want.is_stepping = stp;
    r.want.remaining_steps = rem;
    r.want.status = st;
    plan.push_back(r);
  endtask

  // Send one input transaction; queue what it should produce once it is taken.
  task automatic push_op(input logic [OP_W-1:0] op, input logic dir, input logic [STEPS_W-1:0] n,
                         input logic typed, input pin_frame_t want);
    logic [IN_DATA_W-1:0] word;
    pin_frame_t calc;
    if (idle_mix && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    word = '0;
    word[IN_DIR_BIT] = dir;
    word[IN_STEPS_LSB +: STEPS_W] = n;
    in_tuser <= op;
    in_tdata <= word;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    calc = step_motor(op, dir, n);
    frames_due.push_back(typed ? want : calc);
    if (op == OP_TICK) ticks_sent++;
    else cmds_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(input logic idx, input logic [RATE_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_register(idx, val);
    writes_done++;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate(input int unsigned phase);
    int unsigned roll;
    case (phase)
      0: return RATE_W'(RATE_MAX);
      1: return '0;
      2: return RATE_W'(RATE_DIRECT_MIN);
      3: return RATE_W'(RATE_DIRECT_MIN - 1);
      4: return RATE_W'(RATE_PLUS_MAX);
      default: ;
    endcase
    roll = $urandom_range(0, 9);
    if (roll == 0) return RATE_W'($urandom_range(0, 32767));
    if (roll == 1) return RATE_W'($urandom_range(1, RATE_DIRECT_MIN - 1));
    if (roll == 2) return RATE_W'($urandom_range(RATE_DIRECT_MIN, 1000));
    return RATE_W'($urandom_range(5000, RATE_MAX));
  endfunction

  function automatic logic [STEPS_W-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return $urandom() >> 1;
    return $urandom_range(1, 6);
  endfunction

  // A few timer periods of ticks, capped short and kept within the item budget.
  task automatic tick_burst();
    int unsigned span;
    span = $urandom_range(1, 3 * (int'(period_top) + 1));
    if (span > TICK_BURST_MAX) span = $urandom_range(1, TICK_BURST_MAX);
    if (span > items_left()) span = items_left();
    repeat (span) push_op(OP_TICK, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
  endtask

  task automatic run_phase(input int unsigned phase);
    int unsigned n_items;
    int unsigned kind;
    logic [OP_W-1:0] noise_op;
    drain();
    if (phase < 5 || $urandom_range(0, 4) != 0) write_reg(REG_STEP_RATE, pick_rate(phase));
    if (phase == 1 || phase == 2) write_reg(REG_ENABLE_LEVEL, RATE_W'(phase == 2));
    else if ($urandom_range(0, 2) == 0)
      write_reg(REG_ENABLE_LEVEL, RATE_W'($urandom_range(0, 32767)));
    cfg_valid <= 1'b0;
    n_items = $urandom_range(4, 12);
    repeat (n_items) begin
      if (items_left() == 0) break;
      kind = $urandom_range(0, 99);
      if (motor_state == RUN_OFF && kind < 80) begin
        push_op(OP_INIT, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
      end else if (kind < 20) begin
        push_op(OP_LOAD_START, 1'($urandom_range(0, 1)), pick_count(), 1'b0, '0);
      end else if (kind < 55) begin
        tick_burst();
      end else if (kind < 63) begin
        push_op(OP_STOP, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
      end else if (kind < 71) begin
        push_op(OP_START, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
      end else if (kind < 79) begin
        push_op(OP_LOAD, 1'($urandom_range(0, 1)), pick_count(), 1'b0, '0);
      end else if (kind < 83) begin
        push_op(OP_END, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
      end else if (kind < 86) begin
        push_op(OP_INIT, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
      end else begin
        noise_op = OP_W'($urandom_range(0, 7));
        push_op(noise_op, 1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
      end
    end
    tick_burst();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  // Result side: random stall bursts, none in the calm tail of the run.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_mix && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.step_pulse = out_tdata[OUT_PULSE_BIT];
      seen.direction_level = out_tdata[OUT_DIR_BIT];
      seen.enable_pin = out_tdata[OUT_ENABLE_BIT];
      seen.is_stepping = out_tdata[OUT_STEPPING_BIT];
      seen.remaining_steps = out_tdata[OUT_REM_LSB +: REM_W];
      seen.status = out_tdata[OUT_STATUS_BIT];
      if (seen.step_pulse) pulses_seen++;
      if (frames_due.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", out_tdata);
        faults++;
      end else begin
        due = frames_due.pop_front();
        check_field("step_pulse", due.step_pulse, seen.step_pulse);
        check_field("direction_level", due.direction_level, seen.direction_level);
        check_field("enable_pin", due.enable_pin, seen.enable_pin);
        check_field("is_stepping", due.is_stepping, seen.is_stepping);
        check_field("remaining_steps", due.remaining_steps, seen.remaining_steps);
        check_field("status", due.status, seen.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_motor();
    //     op             dir   steps          typed en    stp   rem           status
    script(OP_TICK,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_START,      1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_LOAD,       1'b1, 32'd5,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_STOP,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_END,        1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_SPARE,      1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_INIT,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_STOP,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_INIT,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_START,      1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_LOAD,       1'b1, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_LOAD,       1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_LOAD,       1'b1, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 31'd0,        1'b1);
    script(OP_LOAD,       1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 31'h7FFF_FFFF, 1'b0);
    script(OP_LOAD_START, 1'b1, 32'd3,         1'b1, 1'b1, 1'b1, 31'd3,        1'b0);
    script(OP_START,      1'b0, 32'd0,         1'b1, 1'b1, 1'b1, 31'd3,        1'b1);
    // loads, but the start half is refused while already stepping
    script(OP_LOAD_START, 1'b0, 32'd7,         1'b1, 1'b1, 1'b1, 31'd7,        1'b1);
    script(OP_STOP,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd7,        1'b0);
    script(OP_STOP,       1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd7,        1'b1);
    script(OP_START,      1'b0, 32'd0,         1'b1, 1'b1, 1'b1, 31'd7,        1'b0);
    script(OP_LOAD,       1'b1, 32'd2,         1'b0, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_END,        1'b0, 32'd0,         1'b1, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_TICK,       1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_INIT,       1'b1, 32'd9,         1'b1, 1'b0, 1'b0, 31'd0,        1'b0);
    script(OP_LOAD_START, 1'b1, 32'd1,         1'b0, 1'b0, 1'b0, 31'd0,        1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) push_op(plan[i].op, plan[i].dir, plan[i].steps, plan[i].typed, plan[i].want);

    phase_no = 0;
    while (items_left() != 0) begin
      idle_mix = (cmds_sent + ticks_sent < CALM_FROM);
      run_phase(phase_no);
      phase_no++;
    end

    drain();
    // let a late divider pass settle before closing out
    repeat (40) @(posedge clk);
    if (frames_due.size() != 0) begin
      $error("%0d result transactions never arrived", frames_due.size());
      faults++;
    end
    $display("Sent %0d commands and %0d timer ticks over %0d phases with %0d register writes.",
             cmds_sent, ticks_sent, phase_no, writes_done);
    $display("Observed %0d step pulses; %0d mismatches.", pulses_seen, faults);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
